FILE: rtl/core/mhms_pkg.sv
// ----------------------------------------------------------------------------
// mhms_pkg: shared types and constants for the minimum Hamming search core
// Field widths, reset values of the running state and both item types.
// ----------------------------------------------------------------------------
package mhms_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned DIST_W  = 7;
   localparam int unsigned TOTAL_W = 16;
   localparam int unsigned COUNT_W = 8;

   // running minimum restarts above any possible distance
   localparam logic [DIST_W-1:0]  MIN_RESET  = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_ZERO = '0;

   // one request item as held in the input stage
   typedef struct packed {
      logic [WORD_W-1:0] query_word_a;
      logic [WORD_W-1:0] query_word_b;
      logic [WORD_W-1:0] cand_word_a;
      logic [WORD_W-1:0] cand_word_b;
      logic              gene_last;
      logic              query_last;
   } req_item_type;

   // one result item as held in the output register
   typedef struct packed {
      logic [DIST_W-1:0]  gene_min;
      logic [WORD_W-1:0]  best_word_a;
      logic [WORD_W-1:0]  best_word_b;
      logic [TOTAL_W-1:0] query_total;
      logic               query_done;
      logic [TOTAL_W-1:0] skip_count;
   } rsp_item_type;

endpackage

FILE: rtl/core/mhms_req_if.sv
// ----------------------------------------------------------------------------
// mhms_req_if: request channel of the minimum Hamming search core
// Valid/ready handshake carrying a query pair, a candidate pair and markers.
// ----------------------------------------------------------------------------
interface mhms_req_if;
   logic                          valid;
   logic                          ready;
   logic [mhms_pkg::WORD_W-1:0]   query_word_a;
   logic [mhms_pkg::WORD_W-1:0]   query_word_b;
   logic [mhms_pkg::WORD_W-1:0]   cand_word_a;
   logic [mhms_pkg::WORD_W-1:0]   cand_word_b;
   logic                          gene_last;
   logic                          query_last;

   modport source (
      output valid, query_word_a, query_word_b, cand_word_a, cand_word_b,
             gene_last, query_last,
      input  ready
   );

   modport sink (
      input  valid, query_word_a, query_word_b, cand_word_a, cand_word_b,
             gene_last, query_last,
      output ready
   );
endinterface

FILE: rtl/core/mhms_rsp_if.sv
// ----------------------------------------------------------------------------
// mhms_rsp_if: result channel of the minimum Hamming search core
// Valid/ready handshake carrying one per-gene result item.
// ----------------------------------------------------------------------------
interface mhms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mhms_pkg::DIST_W-1:0]   gene_min;
   logic [mhms_pkg::WORD_W-1:0]   best_word_a;
   logic [mhms_pkg::WORD_W-1:0]   best_word_b;
   logic [mhms_pkg::TOTAL_W-1:0]  query_total;
   logic                          query_done;
   logic [mhms_pkg::TOTAL_W-1:0]  skip_count;

   modport source (
      output valid, gene_min, best_word_a, best_word_b, query_total,
             query_done, skip_count,
      input  ready
   );

   modport sink (
      input  valid, gene_min, best_word_a, best_word_b, query_total,
             query_done, skip_count,
      output ready
   );
endinterface

FILE: rtl/core/min_hamming_motif_search_core.sv
// ----------------------------------------------------------------------------
// min_hamming_motif_search_core: streaming minimum Hamming distance search
// Tracks the per-gene minimum distance and best candidate, per-query totals
// and the best query total, one request item per cycle unless a result stalls.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink):   one item per candidate: query pair, candidate pair,
//                 gene_last on the last candidate of a gene, query_last
//                 together with gene_last on the last gene of a query.
//   rsp (source): one item per gene_last item: gene minimum, first best
//                 candidate, running query total, query_done, skip count.
//   Path: an accepted item is held in the input register, then its result
//   in the result register, which drives rsp.valid; an item with gene_last
//   can wait in the input stage while the result register is full.
//   Throughput: one item per cycle unless stalled as below; the 128-bit
//   popcount, the compare with the running minimum and the saturating total
//   add are combinational between the input stage and the result register.
//   Stall: while a result waits in the output register, items without
//   gene_last still flow; an item with gene_last waits in the input stage,
//   and req.ready drops only then.
//   Reset: clears both valid flags, restarts the gene minimum, zeroes the
//   query total and sets the best total to all ones.
// ----------------------------------------------------------------------------
module min_hamming_motif_search_core (
   input  logic        clock,
   input  logic        reset,
   mhms_req_if.sink    req,
   mhms_rsp_if.source  rsp
);

   // input stage
   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   mhms_pkg::req_item_type        stage_item_ff;

   // running state
   logic [mhms_pkg::DIST_W-1:0]   running_min_ff,  running_min_in;
   logic [mhms_pkg::WORD_W-1:0]   held_word_a_ff,  held_word_a_in;
   logic [mhms_pkg::WORD_W-1:0]   held_word_b_ff,  held_word_b_in;
   logic [mhms_pkg::TOTAL_W-1:0]  total_sum_ff,    total_sum_in;
   logic [mhms_pkg::TOTAL_W-1:0]  best_total_ff,   best_total_in;

   // result register
   logic                          out_valid_ff, out_valid_in;
   mhms_pkg::rsp_item_type        out_item_ff,  out_item_in;

   logic                          out_free;
   logic                          stage_fire;
   logic                          req_fire;
   logic [mhms_pkg::COUNT_W-1:0]  count_sum;
   logic [mhms_pkg::DIST_W-1:0]   item_dist;
   logic                          hit;
   logic [mhms_pkg::DIST_W-1:0]   gene_min;
   logic [mhms_pkg::TOTAL_W:0]    sum_wide;
   logic [mhms_pkg::TOTAL_W-1:0]  sum_sat;

   // advance the staged item unless it carries a result and the output is full
   assign out_free   = !out_valid_ff || rsp.ready;
   assign stage_fire = stage_valid_ff && (!stage_item_ff.gene_last || out_free);
   assign req.ready  = !stage_valid_ff || stage_fire;
   assign req_fire   = req.valid && req.ready;

   // distance: halved popcount of both xor words
   always_comb begin
      count_sum = mhms_pkg::COUNT_W'($countones(stage_item_ff.query_word_a ^
                                                 stage_item_ff.cand_word_a))
                + mhms_pkg::COUNT_W'($countones(stage_item_ff.query_word_b ^
                                                 stage_item_ff.cand_word_b));
      item_dist = count_sum[mhms_pkg::COUNT_W-1:1];
      hit       = item_dist < running_min_ff;
      gene_min  = hit ? item_dist : running_min_ff;
      sum_wide  = {1'b0, total_sum_ff} + {{(mhms_pkg::TOTAL_W+1-mhms_pkg::DIST_W){1'b0}},
                                          gene_min};
      sum_sat   = sum_wide[mhms_pkg::TOTAL_W] ? mhms_pkg::TOTAL_MAX
                                              : sum_wide[mhms_pkg::TOTAL_W-1:0];
   end

   // update running state and build the result item
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (stage_fire) begin
         stage_valid_in = 1'b0;
      end

      running_min_in = running_min_ff;
      held_word_a_in = held_word_a_ff;
      held_word_b_in = held_word_b_ff;
      total_sum_in   = total_sum_ff;
      best_total_in  = best_total_ff;
      out_item_in    = out_item_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;

      if (stage_fire) begin
         if (hit) begin
            running_min_in = item_dist;
            held_word_a_in = stage_item_ff.cand_word_a;
            held_word_b_in = stage_item_ff.cand_word_b;
         end
         if (stage_item_ff.gene_last) begin
            out_valid_in            = 1'b1;
            out_item_in.gene_min    = gene_min;
            out_item_in.best_word_a = hit ? stage_item_ff.cand_word_a : held_word_a_ff;
            out_item_in.best_word_b = hit ? stage_item_ff.cand_word_b : held_word_b_ff;
            out_item_in.query_total = sum_sat;
            out_item_in.query_done  = stage_item_ff.query_last;
            out_item_in.skip_count  = mhms_pkg::TOTAL_ZERO;
            running_min_in          = mhms_pkg::MIN_RESET;
            total_sum_in            = sum_sat;
            if (stage_item_ff.query_last) begin
               total_sum_in = mhms_pkg::TOTAL_ZERO;
               if (sum_sat < best_total_ff) begin
                  best_total_in = sum_sat;
               end else begin
                  out_item_in.skip_count = sum_sat - best_total_ff;
               end
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         running_min_ff <= mhms_pkg::MIN_RESET;
         total_sum_ff   <= mhms_pkg::TOTAL_ZERO;
         best_total_ff  <= mhms_pkg::TOTAL_MAX;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         running_min_ff <= running_min_in;
         total_sum_ff   <= total_sum_in;
         best_total_ff  <= best_total_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_item_ff.query_word_a <= req.query_word_a;
         stage_item_ff.query_word_b <= req.query_word_b;
         stage_item_ff.cand_word_a  <= req.cand_word_a;
         stage_item_ff.cand_word_b  <= req.cand_word_b;
         stage_item_ff.gene_last    <= req.gene_last;
         stage_item_ff.query_last   <= req.query_last;
      end
      held_word_a_ff <= held_word_a_in;
      held_word_b_ff <= held_word_b_in;
      out_item_ff    <= out_item_in;
   end

   // drive the result channel
   assign rsp.valid       = out_valid_ff;
   assign rsp.gene_min    = out_item_ff.gene_min;
   assign rsp.best_word_a = out_item_ff.best_word_a;
   assign rsp.best_word_b = out_item_ff.best_word_b;
   assign rsp.query_total = out_item_ff.query_total;
   assign rsp.query_done  = out_item_ff.query_done;
   assign rsp.skip_count  = out_item_ff.skip_count;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the minimum Hamming search core
// Drives query/candidate items in random bursts, predicts each per-gene
// result (minimum, first best candidate, query total, skip count) and checks
// every result item against it while the result side stalls on its own.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned RANDOM_ITEMS  = 200;
   localparam int unsigned SAT_GENES     = 1030;
   localparam int unsigned PRINT_CAP     = 40;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam logic [mhms_pkg::DIST_W-1:0] GENE_MIN_IDLE = mhms_pkg::MIN_RESET;

   typedef enum logic [1:0] {RCV_FLOW, RCV_RANDOM, RCV_CHOKE} rcv_mode_type;

   // -------------------------------------------------------------------------
   // Per-gene minimum predictor and store of expected gene results
   // -------------------------------------------------------------------------
   class hamming_min_scoreboard;
      logic [mhms_pkg::DIST_W-1:0]  cur_gene_min;
      logic [mhms_pkg::WORD_W-1:0]  cur_best_a;
      logic [mhms_pkg::WORD_W-1:0]  cur_best_b;
      logic [mhms_pkg::TOTAL_W-1:0] query_sum;
      logic [mhms_pkg::TOTAL_W-1:0] best_query_sum;
      mhms_pkg::rsp_item_type       gene_results_q[$];
      int                           errors;

      function new();
         cur_gene_min   = GENE_MIN_IDLE;
         cur_best_a     = '0;
         cur_best_b     = '0;
         query_sum      = mhms_pkg::TOTAL_ZERO;
         best_query_sum = mhms_pkg::TOTAL_MAX;
         errors         = 0;
      endfunction

      // predict the result, if any, of one accepted candidate item
      function void note_candidate(mhms_pkg::req_item_type it);
         int unsigned                  cand_dist;
         logic [mhms_pkg::TOTAL_W:0]   sum;
         mhms_pkg::rsp_item_type       exp_item;
         cand_dist = ($countones(it.query_word_a ^ it.cand_word_a) +
                      $countones(it.query_word_b ^ it.cand_word_b)) >> 1;
         // keep the first candidate at the minimum: replace on strictly less
         if (cand_dist < cur_gene_min) begin
            cur_gene_min = cand_dist[mhms_pkg::DIST_W-1:0];
            cur_best_a   = it.cand_word_a;
            cur_best_b   = it.cand_word_b;
         end
         if (!it.gene_last) return;
         sum = {1'b0, query_sum} + (mhms_pkg::TOTAL_W+1)'(cur_gene_min);
         if (sum > mhms_pkg::TOTAL_MAX) sum = {1'b0, mhms_pkg::TOTAL_MAX};
         query_sum = sum[mhms_pkg::TOTAL_W-1:0];
         exp_item.gene_min    = cur_gene_min;
         exp_item.best_word_a = cur_best_a;
         exp_item.best_word_b = cur_best_b;
         exp_item.query_total = query_sum;
         exp_item.query_done  = it.query_last;
         exp_item.skip_count  = mhms_pkg::TOTAL_ZERO;
         if (it.query_last) begin
            // equal totals do not count as a new best
            if (query_sum < best_query_sum) best_query_sum = query_sum;
            else exp_item.skip_count = query_sum - best_query_sum;
            query_sum = mhms_pkg::TOTAL_ZERO;
         end
         cur_gene_min = GENE_MIN_IDLE;
         gene_results_q = {gene_results_q, exp_item};
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] gene result error: %s", $time, what);
      endtask

      // compare one accepted result item with the oldest expectation
      task check_gene_result(mhms_pkg::rsp_item_type got);
         mhms_pkg::rsp_item_type exp_item;
         if (gene_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item, gene_min %0d total %0d",
                                      got.gene_min, got.query_total));
            return;
         end
         exp_item = gene_results_q.pop_front();
         if (got.gene_min !== exp_item.gene_min)
            report_mismatch($sformatf("gene_min got %0d expected %0d",
                                      got.gene_min, exp_item.gene_min));
         if (got.best_word_a !== exp_item.best_word_a)
            report_mismatch($sformatf("best_word_a got %h expected %h",
                                      got.best_word_a, exp_item.best_word_a));
         if (got.best_word_b !== exp_item.best_word_b)
            report_mismatch($sformatf("best_word_b got %h expected %h",
                                      got.best_word_b, exp_item.best_word_b));
         if (got.query_total !== exp_item.query_total)
            report_mismatch($sformatf("query_total got %0d expected %0d",
                                      got.query_total, exp_item.query_total));
         if (got.query_done !== exp_item.query_done)
            report_mismatch($sformatf("query_done got %b expected %b",
                                      got.query_done, exp_item.query_done));
         if (got.skip_count !== exp_item.skip_count)
            report_mismatch($sformatf("skip_count got %0d expected %0d",
                                      got.skip_count, exp_item.skip_count));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mhms_req_if req_if ();
   mhms_rsp_if rsp_if ();

   min_hamming_motif_search_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   hamming_min_scoreboard sb = new();

   int unsigned            cycle_count  = 0;
   int unsigned            burst_left   = 0;
   int unsigned            results_seen = 0;
   int unsigned            hold_left    = 0;
   int unsigned            mode_left    = 0;
   rcv_mode_type           rcv_mode     = RCV_FLOW;
   mhms_pkg::rsp_item_type got_item;

   // clock: 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // end the run on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Result side: check accepted items, stall on a pattern, hold off twice
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got_item.gene_min    = rsp_if.gene_min;
         got_item.best_word_a = rsp_if.best_word_a;
         got_item.best_word_b = rsp_if.best_word_b;
         got_item.query_total = rsp_if.query_total;
         got_item.query_done  = rsp_if.query_done;
         got_item.skip_count  = rsp_if.skip_count;
         sb.check_gene_result(got_item);
         results_seen++;
         // long hold-off so the block fills and drops its input ready
         if (results_seen == 40 || results_seen == 700) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rcv_mode  = rcv_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (rcv_mode)
            RCV_FLOW:   rsp_if.ready <= 1'b1;
            RCV_RANDOM: rsp_if.ready <= ($urandom_range(0, 1) == 1);
            default:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // mask with exactly k of the 128 candidate bits flipped against the query
   function automatic logic [2*mhms_pkg::WORD_W-1:0] flip_mask(int unsigned k);
      logic [2*mhms_pkg::WORD_W-1:0] mask;
      mask = '0;
      while ($countones(mask) < k) mask[$urandom_range(0, 2*mhms_pkg::WORD_W-1)] = 1'b1;
      return mask;
   endfunction

   function automatic mhms_pkg::req_item_type make_candidate(
                                          logic [mhms_pkg::WORD_W-1:0] qa,
                                          logic [mhms_pkg::WORD_W-1:0] qb,
                                          logic [2*mhms_pkg::WORD_W-1:0] mask,
                                          logic gl, logic ql);
      mhms_pkg::req_item_type it;
      it.query_word_a = qa;
      it.query_word_b = qb;
      {it.cand_word_a, it.cand_word_b} = {qa, qb} ^ mask;
      it.gene_last  = gl;
      it.query_last = ql;
      return it;
   endfunction

   function automatic logic [mhms_pkg::WORD_W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // offer one item, wait for it to be taken, then maybe end the burst
   task automatic offer_candidate(mhms_pkg::req_item_type it);
      int unsigned gap;
      req_if.valid        <= 1'b1;
      req_if.query_word_a <= it.query_word_a;
      req_if.query_word_b <= it.query_word_b;
      req_if.cand_word_a  <= it.cand_word_a;
      req_if.cand_word_b  <= it.cand_word_b;
      req_if.gene_last    <= it.gene_last;
      req_if.query_last   <= it.query_last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_candidate(it);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(0, 12);
      end
   endtask

   initial begin
      logic [mhms_pkg::WORD_W-1:0]   qa;
      logic [mhms_pkg::WORD_W-1:0]   qb;
      logic [mhms_pkg::WORD_W-1:0]   ra;
      logic [mhms_pkg::WORD_W-1:0]   rb;
      logic [2*mhms_pkg::WORD_W-1:0] mask;
      logic [2*mhms_pkg::WORD_W-1:0] prev_mask;
      mhms_pkg::req_item_type        it;
      int unsigned                   random_items;
      int unsigned                   genes;
      int unsigned                   cands;
      int unsigned                   kmax;
      int unsigned                   k;
      bit                            saturation_done;
      bit                            close_query;
      logic                          gl;
      logic                          ql;

      random_items    = 0;
      saturation_done = 1'b0;
      req_if.valid        <= 1'b0;
      req_if.query_word_a <= '0;
      req_if.query_word_b <= '0;
      req_if.cand_word_a  <= '0;
      req_if.cand_word_b  <= '0;
      req_if.gene_last    <= 1'b0;
      req_if.query_last   <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ties, ignored query marker, equal and worse totals
      ra = rand_word();
      rb = rand_word();
      offer_candidate(make_candidate('0, '0, '1, 1'b1, 1'b0));
      offer_candidate(make_candidate('1, '1, '1, 1'b0, 1'b1));
      offer_candidate(make_candidate(ra, rb, flip_mask(10), 1'b0, 1'b0));
      offer_candidate(make_candidate(ra, rb, flip_mask(11), 1'b1, 1'b1));
      offer_candidate(make_candidate(ra, rb, '1, 1'b1, 1'b0));
      offer_candidate(make_candidate(ra, rb, flip_mask(10), 1'b1, 1'b1));
      offer_candidate(make_candidate(ra, rb, '1, 1'b1, 1'b0));
      offer_candidate(make_candidate(ra, rb, '1, 1'b1, 1'b1));
      offer_candidate(make_candidate(ra, rb, flip_mask(90), 1'b0, 1'b0));
      offer_candidate(make_candidate(ra, rb, flip_mask(60), 1'b0, 1'b0));
      offer_candidate(make_candidate(ra, rb, flip_mask(61), 1'b0, 1'b0));
      offer_candidate(make_candidate(ra, rb, flip_mask(80), 1'b1, 1'b0));
      offer_candidate(make_candidate(ra, rb, flip_mask(7), 1'b1, 1'b0));
      offer_candidate(make_candidate(ra, rb, flip_mask(1), 1'b0, 1'b0));
      offer_candidate(make_candidate(ra, rb, '0, 1'b1, 1'b0));
      offer_candidate(make_candidate(ra, rb, flip_mask(127), 1'b1, 1'b0));
      offer_candidate(make_candidate(ra, rb, '1, 1'b1, 1'b1));

      // random queries; candidates drift closer so new best totals keep coming
      while (random_items < RANDOM_ITEMS) begin
         if (!saturation_done && random_items >= RANDOM_ITEMS / 2) begin
            // one query long enough to saturate the total
            qa = rand_word();
            qb = rand_word();
            for (int unsigned g = 0; g < SAT_GENES; g++)
               offer_candidate(make_candidate(qa, qb, '1, 1'b1, g == SAT_GENES - 1));
            saturation_done = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise: unrelated words and random markers
            it.query_word_a = rand_word();
            it.query_word_b = rand_word();
            it.cand_word_a  = rand_word();
            it.cand_word_b  = rand_word();
            it.gene_last    = 1'($urandom_range(0, 1));
            it.query_last   = 1'($urandom_range(0, 1));
            offer_candidate(it);
            random_items++;
         end else begin
            case ($urandom_range(0, 7))
               0:       begin qa = '0; qb = '0; end
               1:       begin qa = '1; qb = '1; end
               default: begin qa = rand_word(); qb = rand_word(); end
            endcase
            genes       = $urandom_range(1, 5);
            close_query = ($urandom_range(0, 5) != 0);
            prev_mask   = '0;
            for (int unsigned g = 0; g < genes; g++) begin
               cands = $urandom_range(1, 6);
               for (int unsigned c = 0; c < cands; c++) begin
                  // clamp the drift once the item budget is used up
                  kmax = (random_items >= RANDOM_ITEMS) ? 4
                       : 2*mhms_pkg::WORD_W - (random_items * 124) / RANDOM_ITEMS;
                  k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2*mhms_pkg::WORD_W)
                                                   : $urandom_range(0, kmax);
                  // repeat a candidate now and then to force a tie
                  if (c > 0 && $urandom_range(0, 5) == 0) mask = prev_mask;
                  else mask = flip_mask(k);
                  prev_mask = mask;
                  gl = (c == cands - 1);
                  ql = gl ? (close_query && g == genes - 1)
                          : ($urandom_range(0, 7) == 0);
                  offer_candidate(make_candidate(qa, qb, mask, gl, ql));
                  random_items++;
               end
            end
         end
      end

      // drain, then allow for the pipeline latency
      req_if.valid <= 1'b0;
      while (sb.gene_results_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.gene_results_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/mhms_pkg.sv
rtl/core/mhms_req_if.sv
rtl/core/mhms_rsp_if.sv
rtl/core/min_hamming_motif_search_core.sv
tb/tb.sv
